@@ sv/assert_macros.svh @@
// assertion macros shared by the histogram rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GIH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed in %m");
`define GIH_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition in %m");
`else
`define GIH_ASSERT(label, clk, rst, prop)
`define GIH_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ sv/gih_pkg.sv @@
// shared types, constants and helpers of the gray intensity histogram
// no dependencies; used by the top level, gih_luma, gih_store and the testbench
package gih_pkg;

   localparam int BIN_COUNT   = 256;
   localparam int COUNT_WIDTH = 20;
   localparam int BIN_W       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int OUT_W       = 20;
   localparam int WIDE_W      = 32;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [BIN_W-1:0]       bin_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CHART = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // control from the sequencer to the bin store
   typedef struct packed {
      logic    rd_en;
      bin_type rd_addr;
      logic    wr_en;
      bin_type wr_addr;
      logic    clear;
   } store_cmd_type;

   // count to the 20-bit result field, zero extended or truncated
   function automatic logic [OUT_W-1:0] to_out(input count_type value);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(value);
      return wide[OUT_W-1:0];
   endfunction

endpackage

@@ sv/gray_intensity_histogram.sv @@
// top level of the gray intensity histogram: sequencer, peak and result register
// depends on gih_pkg, gih_luma, gih_store and assert_macros.svh
//
// Every request beat passes the idle and then the busy state: the bin store is read
// on the accepting edge and its registered data is modified, written back and
// turned into the result beat in the busy state, so req_stall stays high on the
// cycle after an accept. The busy state covers the registered read of the bin
// memory followed by its write-back. The result sits in an output register, so
// a new request is taken while an earlier result is still waiting on rsp_stall; a
// full output register that is not drained holds the sequencer in its busy state.
// Reset and the clear op empty all bins at once through per-bin valid flags, so
// there is no clearing sweep. Ops: add pixel (gray bin incremented, saturating),
// read bin, read chart pixel, clear. Out-of-range columns read as zero.
`include "assert_macros.svh"

module gray_intensity_histogram (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_bin_index,
   input  logic [19:0] req_chart_row,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_gray,
   output logic [19:0] rsp_bin_count,
   output logic [19:0] rsp_peak,
   output logic [7:0]  rsp_chart_pixel,
   output logic        rsp_row_outside
);
   import gih_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   localparam count_type COUNT_LIMIT = '1;
   localparam logic [8:0] BIN_LIMIT  = 9'(BIN_COUNT);

   // sequencer and result register
   state_type     state_ff,        state_in;
   logic          rsp_valid_ff,    rsp_valid_in;
   logic [7:0]    rsp_gray_ff,     rsp_gray_in;
   logic [19:0]   rsp_count_ff,    rsp_count_in;
   logic [19:0]   rsp_peak_ff,     rsp_peak_in;
   logic [7:0]    rsp_pixel_ff,    rsp_pixel_in;
   logic          rsp_outside_ff,  rsp_outside_in;

   // running peak
   count_type     peak_ff,         peak_in;

   // request beat held over the read cycle
   op_type        op_ff,           op_in;
   logic [7:0]    gray_ff,         gray_in;
   bin_type       addr_ff,         addr_in;
   logic          oob_ff,          oob_in;
   logic [19:0]   row_ff,          row_in;

   logic          accept;
   logic          finish;
   op_type        req_op_dec;
   logic [7:0]    luma_gray;
   bin_type       luma_bin;
   store_cmd_type store_cmd;
   count_type     bin_q;
   count_type     bin_now;
   count_type     bin_bumped;

   logic [WIDE_W-1:0] count_w;
   logic [WIDE_W-1:0] peak_w;
   logic [WIDE_W-1:0] row_w;
   logic [WIDE_W-1:0] top_w;

   gih_luma u_luma (
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .gray  (luma_gray),
      .bin   (luma_bin)
   );

   gih_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .wr_data (bin_bumped),
      .rd_data (bin_q)
   );

   assign req_op_dec = op_type'(req_op);
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   // the busy state completes only when the result register can take the beat
   assign finish     = (state_ff == ST_BUSY) && (!rsp_valid_ff || !rsp_stall);

   // capture the request; the store read is issued on the same edge
   always_comb begin
      op_in   = op_ff;
      gray_in = gray_ff;
      addr_in = addr_ff;
      oob_in  = oob_ff;
      row_in  = row_ff;
      if (accept) begin
         op_in   = req_op_dec;
         gray_in = (req_op_dec == OP_ADD) ? luma_gray : 8'd0;
         addr_in = (req_op_dec == OP_ADD) ? luma_bin : req_bin_index[BIN_W-1:0];
         oob_in  = (req_op_dec != OP_ADD) && (9'(req_bin_index) >= BIN_LIMIT);
         row_in  = req_chart_row;
      end
   end

   // reads only in idle, writes only in the finishing cycle: never together
   always_comb begin
      store_cmd         = '0;
      store_cmd.rd_en   = accept;
      store_cmd.rd_addr = addr_in;
      store_cmd.wr_en   = finish && (op_ff == OP_ADD);
      store_cmd.wr_addr = addr_ff;
      store_cmd.clear   = finish && (op_ff == OP_CLEAR);
   end

   // modify step: saturating increment and chart compare
   always_comb begin
      bin_now    = oob_ff ? '0 : bin_q;
      bin_bumped = (bin_now == COUNT_LIMIT) ? bin_now : bin_now + count_type'(1);
      count_w    = WIDE_W'(bin_now);
      peak_w     = WIDE_W'(peak_ff);
      row_w      = WIDE_W'(row_ff);
      top_w      = (count_w <= peak_w) ? (peak_w - count_w) : '0;
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      peak_in        = peak_ff;
      rsp_gray_in    = rsp_gray_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_peak_in    = rsp_peak_ff;
      rsp_pixel_in   = rsp_pixel_ff;
      rsp_outside_in = rsp_outside_ff;
      if (accept) begin
         state_in = ST_BUSY;
      end
      if (finish) begin
         state_in       = ST_IDLE;
         rsp_valid_in   = 1'b1;
         rsp_gray_in    = gray_ff;
         rsp_count_in   = '0;
         rsp_pixel_in   = 8'd0;
         rsp_outside_in = 1'b0;
         unique case (op_ff)
            OP_ADD: begin
               if (bin_bumped > peak_ff) begin
                  peak_in = bin_bumped;
               end
               rsp_count_in = to_out(bin_bumped);
            end
            OP_READ: begin
               rsp_count_in = to_out(bin_now);
            end
            OP_CHART: begin
               rsp_pixel_in   = (row_w >= top_w) ? 8'd0 : 8'd255;
               rsp_outside_in = (row_w >= peak_w);
            end
            OP_CLEAR: begin
               peak_in = '0;
            end
            default: begin
               rsp_count_in = '0;
            end
         endcase
         rsp_peak_in = to_out(peak_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         peak_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
      end
      op_ff          <= op_in;
      gray_ff        <= gray_in;
      addr_ff        <= addr_in;
      oob_ff         <= oob_in;
      row_ff         <= row_in;
      rsp_gray_ff    <= rsp_gray_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_peak_ff    <= rsp_peak_in;
      rsp_pixel_ff   <= rsp_pixel_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gray        = rsp_gray_ff;
   assign rsp_bin_count   = rsp_count_ff;
   assign rsp_peak        = rsp_peak_ff;
   assign rsp_chart_pixel = rsp_pixel_ff;
   assign rsp_row_outside = rsp_outside_ff;

   // checks
   `GIH_ASSERT_NEVER(a_store_no_overlap, clock, reset, store_cmd.rd_en && store_cmd.wr_en)
   `GIH_ASSERT(a_peak_covers_add, clock, reset, (finish && op_ff == OP_ADD) |-> (peak_in >= bin_bumped))
   `GIH_ASSERT(a_clear_zeroes_peak, clock, reset, (finish && op_ff == OP_CLEAR) |=> (peak_ff == '0))
   `GIH_ASSERT(a_finish_gives_beat, clock, reset, finish |=> rsp_valid)

endmodule

@@ sv/gih_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies; used by the bin store
module gih_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 20
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/gih_luma.sv @@
// rgb to gray conversion in q8 fixed point and gray to bin mapping
// depends on gih_pkg
module gih_luma (
   input  logic [7:0]     red,
   input  logic [7:0]     green,
   input  logic [7:0]     blue,
   output logic [7:0]     gray,
   output gih_pkg::bin_type bin
);
   import gih_pkg::*;

   localparam logic [15:0] COEF_R = 16'd54;
   localparam logic [15:0] COEF_G = 16'd184;
   localparam logic [15:0] COEF_B = 16'd18;

   logic [15:0] weighted;
   logic [16:0] scaled;

   // weights sum to 256, so the sum stays below 2^16
   assign weighted = COEF_R * 16'(red) + COEF_G * 16'(green) + COEF_B * 16'(blue);
   assign gray     = weighted[15:8];

   // bin = gray * BIN_COUNT / 256
   assign scaled = 17'(gray) * 17'(BIN_COUNT);
   assign bin    = scaled[8 +: BIN_W];

endmodule

@@ sv/gih_store.sv @@
// bin count store: ram plus one valid flag per bin, invalid bins read as zero
// depends on gih_pkg and gih_ram
module gih_store (
   input  logic                   clock,
   input  logic                   reset,
   input  gih_pkg::store_cmd_type cmd,
   input  gih_pkg::count_type     wr_data,
   output gih_pkg::count_type     rd_data
);
   import gih_pkg::*;

   logic [BIN_COUNT-1:0] valid_ff;
   logic [BIN_COUNT-1:0] valid_in;
   logic                 rd_valid_ff;
   logic                 rd_valid_in;
   count_type            ram_q;

   gih_ram #(
      .DEPTH (BIN_COUNT),
      .WIDTH (COUNT_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
      rd_valid_in = cmd.rd_en ? valid_ff[cmd.rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? ram_q : '0;

endmodule

@@ tb/sv/gray_intensity_histogram_test.sv @@
// self-checking testbench of the gray intensity histogram: directed and random beats
// depends on gih_pkg and the gray_intensity_histogram rtl; keeps its own shadow of the bins
module gray_intensity_histogram_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gih_pkg::*;

   // generous bound: every beat with the longest random gap on both sides plus the long hold-off
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 8;

   // one expected result beat, one member per result port
   typedef struct packed {
      logic [7:0]  gray;
      logic [19:0] bin_count;
      logic [19:0] peak;
      logic [7:0]  chart_pixel;
      logic        row_outside;
   } histogram_answer_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic [7:0]  req_bin_index;
   logic [19:0] req_chart_row;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_gray;
   logic [19:0] rsp_bin_count;
   logic [19:0] rsp_peak;
   logic [7:0]  rsp_chart_pixel;
   logic        rsp_row_outside;

   // shadow copy of the histogram, advanced at every accepted request beat
   count_type shadow_bins [BIN_COUNT];
   count_type shadow_peak;
   histogram_answer_type histogram_answers_q [$];

   // idling controls shared by the sender, the receiver and the tests
   bit tx_idling;
   bit rx_idling;
   int tx_quiet;
   int rx_quiet;
   int rx_burst;
   int rx_hold_left;

   int error_count;
   int cycle_count;
   int beats_checked;
   int add_count;
   int read_count;
   int chart_count;
   int clear_count;
   count_type highest_peak;

   gray_intensity_histogram i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_bin_index   (req_bin_index),
      .req_chart_row   (req_chart_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gray        (rsp_gray),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_peak        (rsp_peak),
      .rsp_chart_pixel (rsp_chart_pixel),
      .rsp_row_outside (rsp_row_outside)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles, %0d results still pending",
                  cycle_count, histogram_answers_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_error(string msg);
      $display("%0t ns  mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // shadow histogram: applies one request and returns the result it must produce
   function automatic histogram_answer_type apply_histogram_op(
      op_type op, logic [7:0] red, logic [7:0] green, logic [7:0] blue,
      logic [7:0] column, logic [19:0] row);
      histogram_answer_type answer;
      int unsigned weighted;
      int unsigned slot;
      count_type column_count;
      count_type bar_top;
      answer = '0;
      // ops 1 and 2 see an out-of-range column as an empty bin
      column_count = (int'(column) < BIN_COUNT) ? shadow_bins[column] : '0;
      case (op)
         OP_ADD: begin
            // q8 luma weights 0.21 / 0.72 / 0.07, truncated
            weighted = 54 * red + 184 * green + 18 * blue;
            answer.gray = 8'(weighted >> 8);
            slot = (int'(answer.gray) * BIN_COUNT) >> 8;
            if (slot >= BIN_COUNT)
               slot = BIN_COUNT - 1;
            // saturating count
            if (shadow_bins[slot] != '1)
               shadow_bins[slot] = shadow_bins[slot] + count_type'(1);
            if (shadow_bins[slot] > shadow_peak)
               shadow_peak = shadow_bins[slot];
            answer.bin_count = 20'(shadow_bins[slot]);
         end
         OP_READ: begin
            answer.bin_count = 20'(column_count);
         end
         OP_CHART: begin
            // bar occupies the rows from peak - count down to the bottom
            bar_top = (column_count <= shadow_peak) ? shadow_peak - column_count : '0;
            answer.chart_pixel = (row >= bar_top) ? 8'd0 : 8'd255;
            answer.row_outside = (row >= shadow_peak);
         end
         default: begin
            foreach (shadow_bins[i])
               shadow_bins[i] = '0;
            shadow_peak = '0;
         end
      endcase
      answer.peak = 20'(shadow_peak);
      return answer;
   endfunction

   // both sides of the block, sampled at the rising edge: the result beat is checked
   // first, then an accepted request beat is predicted into the queue
   always @(posedge clock) begin : watch_ports
      histogram_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (histogram_answers_q.size() == 0) begin
            report_error("result beat with no request pending");
         end else begin
            want = histogram_answers_q.pop_front();
            check_field("gray", rsp_gray, want.gray);
            check_field("bin_count", rsp_bin_count, want.bin_count);
            check_field("peak", rsp_peak, want.peak);
            check_field("chart_pixel", rsp_chart_pixel, want.chart_pixel);
            check_field("row_outside", rsp_row_outside, want.row_outside);
            beats_checked++;
         end
      end
      if (!reset && req_valid && !req_stall) begin
         histogram_answers_q.push_back(apply_histogram_op(op_type'(req_op), req_red,
            req_green, req_blue, req_bin_index, req_chart_row));
         if (shadow_peak > highest_peak)
            highest_peak = shadow_peak;
         case (op_type'(req_op))
            OP_ADD:   add_count++;
            OP_READ:  read_count++;
            OP_CHART: chart_count++;
            default:  clear_count++;
         endcase
      end
   end

   // receiver: long hold-off wins; no stall unless idling, else random stall bursts, quiet runs
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rx_hold_left--;
         end else if (!rx_idling) begin
            rsp_stall <= 1'b0;
         end else if (rx_burst > 0) begin
            rsp_stall <= 1'b1;
            rx_burst--;
         end else if (rx_quiet > 0) begin
            rsp_stall <= 1'b0;
            rx_quiet--;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            rx_burst = $urandom_range(1, 16) - 1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 15) == 0)
               rx_quiet = $urandom_range(10, 40);
         end
      end
   end

   // offers one request beat from a falling edge and returns on the falling edge after
   // it was taken; valid stays high into the next beat unless a gap follows
   task automatic send_beat(op_type op, logic [7:0] red, logic [7:0] green,
                            logic [7:0] blue, logic [7:0] column, logic [19:0] row);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_red       <= red;
      req_green     <= green;
      req_blue      <= blue;
      req_bin_index <= column;
      req_chart_row <= row;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      @(negedge clock);
      if (tx_idling) begin
         if (tx_quiet > 0) begin
            tx_quiet--;
         end else if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else if ($urandom_range(0, 15) == 0) begin
            tx_quiet = $urandom_range(10, 40);
         end
      end
   endtask

   // fresh histogram: empty bins, zero peak, every chart row is at or past the peak
   task automatic test_after_reset();
      send_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 20'd0);
      send_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255, 20'd0);
      send_beat(OP_CHART, 8'd0, 8'd0, 8'd0, 8'd0, 20'd0);
   endtask

   // black, white, the pure primaries and a repeated mid gray to build a peak of 3
   task automatic test_pixel_extremes();
      send_beat(OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0, 20'd0);
      send_beat(OP_ADD, 8'd255, 8'd255, 8'd255, 8'd0, 20'd0);
      send_beat(OP_ADD, 8'd255, 8'd0, 8'd0, 8'd0, 20'd0);
      send_beat(OP_ADD, 8'd0, 8'd255, 8'd0, 8'd0, 20'd0);
      send_beat(OP_ADD, 8'd0, 8'd0, 8'd255, 8'd0, 20'd0);
      repeat (3) send_beat(OP_ADD, 8'd100, 8'd100, 8'd100, 8'd0, 20'd0);
      send_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd100, 20'd0);
      send_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd53, 20'd0);
   endtask

   // chart around the bar top and the peak, an empty column and the deepest row
   task automatic test_chart_rows();
      send_beat(OP_CHART, 8'd0, 8'd0, 8'd0, 8'd100, 20'd0);
      send_beat(OP_CHART, 8'd0, 8'd0, 8'd0, 8'd0, 20'd1);
      send_beat(OP_CHART, 8'd0, 8'd0, 8'd0, 8'd0, 20'd2);
      send_beat(OP_CHART, 8'd0, 8'd0, 8'd0, 8'd0, 20'd3);
      send_beat(OP_CHART, 8'd0, 8'd0, 8'd0, 8'd7, 20'd2);
      send_beat(OP_CHART, 8'd0, 8'd0, 8'd0, 8'd255, 20'hFFFFF);
   endtask

   // clear drops every bin and the peak
   task automatic test_clear();
      send_beat(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 20'd0);
      send_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd100, 20'd0);
      send_beat(OP_CHART, 8'd0, 8'd0, 8'd0, 8'd100, 20'd0);
   endtask

   // random beats; half the pixels come from a small gray palette so that bins pile up
   // and the chart has tall bars; rows mostly land near the peak
   task automatic test_random_mix(int beats);
      logic [7:0] palette [6];
      logic [7:0] level;
      logic [7:0] column;
      logic [19:0] row;
      int pick;
      foreach (palette[i])
         palette[i] = 8'($urandom_range(0, 255));
      repeat (beats) begin
         level = palette[$urandom_range(0, 5)];
         column = ($urandom_range(0, 1) == 0) ? level : 8'($urandom_range(0, 255));
         if ($urandom_range(0, 9) < 7)
            row = 20'($urandom_range(0, int'(shadow_peak) + 2));
         else
            row = 20'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 2)
            send_beat(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), column, row);
         else if (pick < 30)
            send_beat(OP_ADD, level, level, level, column, row);
         else if (pick < 60)
            send_beat(OP_ADD, 8'($urandom), 8'($urandom), 8'($urandom), column, row);
         else if (pick < 75)
            send_beat(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), column, row);
         else
            send_beat(OP_CHART, 8'($urandom), 8'($urandom), 8'($urandom), column, row);
      end
   endtask

   // receiver holds off long enough for the output register to fill and the block to
   // push back on the request side while beats keep coming
   task automatic test_backpressure();
      rx_hold_left = 150;
      test_random_mix(24);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_ADD;
      req_red       = '0;
      req_green     = '0;
      req_blue      = '0;
      req_bin_index = '0;
      req_chart_row = '0;
      tx_idling     = 1'b1;
      rx_idling     = 1'b1;
      foreach (shadow_bins[i])
         shadow_bins[i] = '0;
      shadow_peak = '0;
      highest_peak = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_after_reset();
      test_pixel_extremes();
      test_chart_rows();
      test_clear();
      test_random_mix(580);
      test_backpressure();
      // closing stretch runs at full rate on both sides
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      test_random_mix(220);

      req_valid <= 1'b0;
      while (histogram_answers_q.size() != 0)
         @(posedge clock);
      // a stray extra result would show up within the pipeline depth
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("stimulus: %0d pixel adds, %0d bin reads, %0d chart reads, %0d clears",
               add_count, read_count, chart_count, clear_count);
      $display("checked %0d result beats, highest peak %0d, %0d mismatches",
               beats_checked, highest_peak, error_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/gih_pkg.sv
sv/gih_ram.sv
sv/gih_luma.sv
sv/gih_store.sv
sv/gray_intensity_histogram.sv
tb/sv/gray_intensity_histogram_test.sv
